/* design/ccs_pkg.sv */
package ccs_pkg;

	localparam int RATE_W = 17;
	localparam int REQ_W  = 18;
	localparam int STEP_W = 4;

	localparam logic [RATE_W-1:0] RATE_8K   = 17'd8000;
	localparam logic [RATE_W-1:0] RATE_32K  = 17'd32000;
	localparam logic [RATE_W-1:0] RATE_44K1 = 17'd44100;
	localparam logic [RATE_W-1:0] RATE_48K  = 17'd48000;
	localparam logic [RATE_W-1:0] RATE_88K2 = 17'd88200;
	localparam logic [RATE_W-1:0] RATE_96K  = 17'd96000;

	typedef enum logic [1:0] {
		ACT_POWER  = 2'd0,
		ACT_RATE   = 2'd1,
		ACT_VOLUME = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		PWR_NONE    = 2'd0,
		PWR_OFF     = 2'd1,
		PWR_STANDBY = 2'd2,
		PWR_ON      = 2'd3
	} power_t;

	typedef enum logic [1:0] {
		KIND_WRITE     = 2'd0,
		KIND_CLK_SET   = 2'd1,
		KIND_CLK_CLEAR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		SEQ_ON      = 3'd0,
		SEQ_STANDBY = 3'd1,
		SEQ_OFF     = 3'd2,
		SEQ_RATE    = 3'd3,
		SEQ_VOLUME  = 3'd4
	} seq_t;

	typedef struct packed {
		seq_t              seq;
		logic              gen;
		logic [7:0]        word;
		logic [7:0]        vol_data;
		logic [RATE_W-1:0] rate;
	} job_t;

endpackage

/* design/codec_control_sequencer_unit.sv */
// channel  dir  handshake            payload
// cmd      in   cmd_valid/cmd_stall  action, power_target, rate_request, volume_db
// res      out  res_valid/res_stall  kind, reg_byte, data_byte, granted_rate, last
// cfg      in   cfg_valid/cfg_ready  cfg_data (hw_is_third_gen)
//
// One result per cycle while res_stall is low; a request yields 0, 1, 3, 5 or
// 10 results, set by the back end's step counter, via queue and output reg.
// Requests are taken every cycle while the request queue has room.
// Reset: power state none, rate 44100, third-gen off, queue and output empty.
// res_stall holds the output register; cmd_stall rises when the queue is full.
module codec_control_sequencer_unit import ccs_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  logic [1:0]        action,
	input  logic [1:0]        power_target,
	input  logic [REQ_W-1:0]  rate_request,
	input  logic signed [7:0] volume_db,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [1:0]        kind,
	output logic [7:0]        reg_byte,
	output logic [7:0]        data_byte,
	output logic [RATE_W-1:0] granted_rate,
	output logic              last
);

	logic gen_q;
	logic push;
	logic pop;
	logic full;
	logic head_valid;
	job_t job;
	job_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gen_q <= 1'b0;
		else if (cfg_valid)
			gen_q <= cfg_data;
	end

	ccs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.action       (action),
		.power_target (power_target),
		.rate_request (rate_request),
		.volume_db    (volume_db),
		.gen          (gen_q),
		.full         (full),
		.push         (push),
		.job          (job)
	);

	ccs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wdata      (job),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (full)
	);

	ccs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.kind         (kind),
		.reg_byte     (reg_byte),
		.data_byte    (data_byte),
		.granted_rate (granted_rate),
		.last         (last)
	);

endmodule

/* design/ccs_front.sv */
module ccs_front import ccs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  logic [1:0]        action,
	input  logic [1:0]        power_target,
	input  logic [REQ_W-1:0]  rate_request,
	input  logic signed [7:0] volume_db,
	input  logic              gen,
	input  logic              full,
	output logic              push,
	output job_t              job
);

	typedef struct packed {
		logic [7:0]        word;
		logic [RATE_W-1:0] rate;
	} rate_pick_t;

	function automatic rate_pick_t rate_map(input logic [REQ_W-1:0] req, input logic g);
		rate_pick_t p;
		if (req <= {1'b0, RATE_8K}) begin
			p.word = g ? 8'h4d : 8'h45;
			p.rate = RATE_8K;
		end else if (req <= {1'b0, RATE_32K}) begin
			p.word = 8'h59;
			p.rate = RATE_32K;
		end else if (req <= {1'b0, RATE_44K1}) begin
			p.word = 8'h63;
			p.rate = RATE_44K1;
		end else if (req <= {1'b0, RATE_48K}) begin
			p.word = 8'h41;
			p.rate = RATE_48K;
		end else if (req <= {1'b0, RATE_88K2}) begin
			p.word = 8'h7f;
			p.rate = RATE_88K2;
		end else begin
			p.word = 8'h5f;
			p.rate = RATE_96K;
		end
		return p;
	endfunction

	logic              accept;
	logic              emits;
	logic [1:0]        power_state_q;
	logic [1:0]        next_power;
	logic [RATE_W-1:0] rate_q;
	logic [RATE_W-1:0] next_rate;
	rate_pick_t        req_pick;
	rate_pick_t        cur_pick;
	logic signed [7:0] vol_c;

	assign cmd_stall = full;
	assign accept    = cmd_valid && !full;
	assign push      = accept && emits;

	assign req_pick = rate_map(rate_request, gen);
	assign cur_pick = rate_map({1'b0, rate_q}, gen);

	always_comb begin
		if (volume_db > 8'sd6)
			vol_c = 8'sd6;
		else if (volume_db < -8'sd73)
			vol_c = -8'sd73;
		else
			vol_c = volume_db;
	end

	always_comb begin
		emits      = 1'b0;
		next_power = power_state_q;
		next_rate  = rate_q;
		job.seq    = SEQ_VOLUME;
		job.word   = cur_pick.word;
		case (action_t'(action))
			ACT_POWER: begin
				if (power_target != PWR_NONE && power_target != power_state_q) begin
					emits      = 1'b1;
					next_power = power_target;
					case (power_t'(power_target))
						PWR_ON:      job.seq = SEQ_ON;
						PWR_STANDBY: job.seq = SEQ_STANDBY;
						default:     job.seq = SEQ_OFF;
					endcase
				end
			end
			ACT_RATE: begin
				emits     = 1'b1;
				job.seq   = SEQ_RATE;
				job.word  = req_pick.word;
				next_rate = req_pick.rate;
			end
			ACT_VOLUME: begin
				emits   = 1'b1;
				job.seq = SEQ_VOLUME;
			end
			default: ;
		endcase
		job.gen      = gen;
		job.vol_data = 8'(vol_c) + 8'd121;
		job.rate     = next_rate;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_state_q <= PWR_NONE;
			rate_q        <= RATE_44K1;
		end else if (accept) begin
			power_state_q <= next_power;
			rate_q        <= next_rate;
		end
	end

	a_on_moves_state: assert property (@(posedge clk) disable iff (!arst_n)
		push && job.seq == SEQ_ON |=> power_state_q == PWR_ON)
		else $error("power state not on after power-on request");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("request pushed into full queue");

endmodule

/* design/ccs_queue.sv */
module ccs_queue import ccs_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wdata,
	input  logic pop,
	output job_t head,
	output logic head_valid,
	output logic full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign head_valid = count_q != '0;
	assign full       = count_q == CNT_W'(DEPTH);
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			if (push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_pop_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

/* design/ccs_back.sv */
module ccs_back import ccs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  job_t              head,
	output logic              pop,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [1:0]        kind,
	output logic [7:0]        reg_byte,
	output logic [7:0]        data_byte,
	output logic [RATE_W-1:0] granted_rate,
	output logic              last
);

	typedef struct packed {
		kind_t      kind;
		logic [7:0] reg_byte;
		logic [7:0] data_byte;
		logic       last;
	} step_t;

	function automatic step_t wr(input logic [7:0] r, input logic [7:0] d, input logic l);
		step_t s;
		s.kind      = KIND_WRITE;
		s.reg_byte  = r;
		s.data_byte = d;
		s.last      = l;
		return s;
	endfunction

	function automatic step_t clk_op(input kind_t k, input logic l);
		step_t s;
		s.kind      = k;
		s.reg_byte  = 8'h00;
		s.data_byte = 8'h02;
		s.last      = l;
		return s;
	endfunction

	function automatic step_t seq_step(input job_t j, input logic [STEP_W-1:0] n);
		step_t s;
		s = wr(8'h05, j.vol_data, 1'b1);
		case (j.seq)
			SEQ_ON: begin
				case (n)
					4'd0:    s = clk_op(KIND_CLK_SET, 1'b0);
					4'd1:    s = wr(8'h0c, 8'h67, 1'b0);
					4'd2:    s = wr(8'h12, 8'h00, 1'b0);
					4'd3:    s = wr(8'h08, j.gen ? 8'h18 : 8'h10, 1'b0);
					4'd4:    s = wr(8'h0a, 8'h00, 1'b0);
					4'd5:    s = wr(8'h0e, 8'h4a, 1'b0);
					4'd6:    s = wr(8'h12, 8'h00, 1'b0);
					4'd7:    s = wr(8'h10, j.word, 1'b0);
					4'd8:    s = wr(8'h12, 8'h01, 1'b0);
					default: s = wr(8'h12, 8'h01, 1'b1);
				endcase
			end
			SEQ_STANDBY: begin
				case (n)
					4'd0:    s = clk_op(KIND_CLK_SET, 1'b0);
					4'd1:    s = wr(8'h0a, 8'h08, 1'b0);
					4'd2:    s = wr(8'h08, 8'h00, 1'b0);
					4'd3:    s = wr(8'h0c, 8'h6f, 1'b0);
					default: s = wr(8'h0c, 8'h7f, 1'b1);
				endcase
			end
			SEQ_OFF: begin
				case (n)
					4'd0:    s = wr(8'h0a, 8'h08, 1'b0);
					4'd1:    s = wr(8'h08, 8'h00, 1'b0);
					4'd2:    s = wr(8'h0c, 8'h6f, 1'b0);
					4'd3:    s = wr(8'h0c, 8'hff, 1'b0);
					default: s = clk_op(KIND_CLK_CLEAR, 1'b1);
				endcase
			end
			SEQ_RATE: begin
				case (n)
					4'd0:    s = wr(8'h12, 8'h00, 1'b0);
					4'd1:    s = wr(8'h10, j.word, 1'b0);
					default: s = wr(8'h12, 8'h01, 1'b1);
				endcase
			end
			default: s = wr(8'h05, j.vol_data, 1'b1);
		endcase
		return s;
	endfunction

	logic [STEP_W-1:0] step_q;
	logic              res_valid_q;
	logic              adv;
	step_t             cur;
	step_t             out_q;
	logic [RATE_W-1:0] rate_q;

	assign cur = seq_step(head, step_q);
	assign adv = head_valid && (!res_valid_q || !res_stall);
	assign pop = adv && cur.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv)
				step_q <= cur.last ? '0 : step_q + 1'b1;
			if (adv)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q  <= cur;
			rate_q <= head.rate;
		end
	end

	assign res_valid    = res_valid_q;
	assign kind         = out_q.kind;
	assign reg_byte     = out_q.reg_byte;
	assign data_byte    = out_q.data_byte;
	assign granted_rate = rate_q;
	assign last         = out_q.last;

	a_mid_run_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != '0 |-> head_valid)
		else $error("sequence step without a request at queue head");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= 4'd9)
		else $error("sequence step beyond longest run");

endmodule
